FILE: design/odsa_pkg.sv
package odsa_pkg;

   // Operand size: each octal digit carries three bits.
   localparam int MAX_DIGITS = 10;
   localparam int DIGIT_W    = 3;
   localparam int VAL_W      = DIGIT_W * MAX_DIGITS;
   localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
   localparam int CNT_W      = $clog2(VAL_W + 1);

   localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_DIGITS);
   localparam logic [5:0]       ASCII_ZERO = 6'd48;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_EQ  = 3'd4,
      OP_NE  = 3'd5,
      OP_LT  = 3'd6,
      OP_GT  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      KIND_DIGIT = 2'd0,
      KIND_TRUTH = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_TOO_MANY = 3'd1,
      ERR_NEGATIVE = 3'd2,
      ERR_DIV_ZERO = 3'd3,
      ERR_TOO_LONG = 3'd4
   } err_type;

   // Control into the multiply/divide unit.
   typedef struct packed {
      logic start;
      logic divide;
   } mdu_ctl_type;

   // Status back from the multiply/divide unit.
   typedef struct packed {
      logic done;
      logic overflow;
   } mdu_sts_type;

endpackage

FILE: design/odsa_muldiv.sv
module odsa_muldiv
   import odsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mdu_ctl_type      ctl,
   input  logic [VAL_W-1:0] value_a,
   input  logic [VAL_W-1:0] value_b,
   output mdu_sts_type      sts,
   output logic [VAL_W-1:0] result
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             div_ff, div_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [VAL_W-1:0] shf_ff, shf_in;
   logic [VAL_W-1:0] opd_ff, opd_in;
   logic [VAL_W+1:0] prod_step;
   logic [VAL_W+1:0] trial;
   logic             fits;

   // One multiplier bit per cycle, most significant first: acc = 2*acc + bit*a.
   assign prod_step = {1'b0, acc_ff, 1'b0}
                    + (shf_ff[VAL_W-1] ? {2'b00, opd_ff} : {(VAL_W + 2){1'b0}});

   // Restoring division: one quotient bit per cycle from the dividend's top bit.
   assign trial = {1'b0, acc_ff, shf_ff[VAL_W-1]} - {2'b00, opd_ff};
   assign fits  = ~trial[VAL_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      shf_in  = shf_ff;
      opd_in  = opd_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.divide;
         ovf_in  = 1'b0;
         cnt_in  = CNT_W'(VAL_W);
         acc_in  = '0;
         opd_in  = ctl.divide ? value_b : value_a;
         shf_in  = ctl.divide ? value_a : value_b;
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_in = fits ? trial[VAL_W-1:0] : {acc_ff[VAL_W-2:0], shf_ff[VAL_W-1]};
            shf_in = {shf_ff[VAL_W-2:0], fits};
         end else begin
            // Once the running product passes the range it can only grow.
            acc_in = prod_step[VAL_W-1:0];
            ovf_in = ovf_ff | (|prod_step[VAL_W+1:VAL_W]);
            shf_in = {shf_ff[VAL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      shf_ff <= shf_in;
      opd_ff <= opd_in;
   end

   assign sts.done     = done_ff;
   assign sts.overflow = ovf_ff;
   assign result       = div_ff ? shf_ff : acc_ff;

endmodule

FILE: design/octal_digit_string_alu.sv
// Octal string ALU. Two unsigned numbers arrive as ASCII octal digits, least
// significant first, one digit per beat: operand A, then operand B. Digit beats
// are taken one per cycle and give no result. The beat that carries B's last
// digit and the opcode starts the operation, and the input stalls until the last
// result beat of that operation is in the output register. An operation first
// aligns the operands in their digit shift registers, then does add, subtract
// and the compares directly or runs multiply or divide in the bit-serial unit,
// and then sends one result beat per cycle unless the output side stalls (one
// beat per result digit, or a single beat for a compare, an error or a zero
// result). Digits are taken from the low three bits of the character. An operand
// longer than MAX_DIGITS digits makes the operation report the operand-too-long
// error.
module octal_digit_string_alu
   import odsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_second_operand,
   input  logic [5:0] req_digit_char,
   input  logic       req_last_digit,
   input  logic [2:0] req_opcode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [5:0] rsp_result_char,
   output logic       rsp_truth,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last_result
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ALIGN = 4'b0010,
      ST_ITER  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [VAL_W-1:0] a_ff, a_in;
   logic [VAL_W-1:0] b_ff, b_in;
   logic [LEN_W-1:0] len_a_ff, len_a_in;
   logic [LEN_W-1:0] len_b_ff, len_b_in;
   logic [LEN_W-1:0] pad_a_ff, pad_a_in;
   logic [LEN_W-1:0] pad_b_ff, pad_b_in;
   logic             overlong_ff, overlong_in;
   op_type           op_ff, op_in;

   // Pending result of the current operation.
   logic             num_ff, num_in;
   logic [VAL_W-1:0] res_ff, res_in;
   kind_type         ekind_ff, ekind_in;
   logic             etruth_ff, etruth_in;
   err_type          eerr_ff, eerr_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         okind_ff, okind_in;
   logic [5:0]       ochar_ff, ochar_in;
   logic             otruth_ff, otruth_in;
   err_type          oerr_ff, oerr_in;
   logic             olast_ff, olast_in;

   logic             accept;
   logic [DIGIT_W-1:0] digit;
   logic             slot_free;
   logic             aligned;
   logic             eq, lt, gt;
   logic [VAL_W:0]   sum, diff;
   logic [VAL_W-1:0] res_next;
   mdu_ctl_type      mdu_ctl;
   mdu_sts_type      mdu_sts;
   logic [VAL_W-1:0] mdu_result;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign digit     = req_digit_char[DIGIT_W-1:0];
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign aligned   = (pad_a_ff == MAX_LEN) && (pad_b_ff == MAX_LEN);

   // Compares and combinational add and subtract on the aligned operands.
   assign eq   = (len_a_ff == len_b_ff) && (a_ff == b_ff);
   assign lt   = (len_a_ff < len_b_ff) || ((len_a_ff == len_b_ff) && (a_ff < b_ff));
   assign gt   = (len_a_ff > len_b_ff) || ((len_a_ff == len_b_ff) && (a_ff > b_ff));
   assign sum  = {1'b0, a_ff} + {1'b0, b_ff};
   assign diff = {1'b0, a_ff} - {1'b0, b_ff};

   assign res_next = {{DIGIT_W{1'b0}}, res_ff[VAL_W-1:DIGIT_W]};

   odsa_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mdu_ctl),
      .value_a (a_ff),
      .value_b (b_ff),
      .sts     (mdu_sts),
      .result  (mdu_result)
   );

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      pad_a_in     = pad_a_ff;
      pad_b_in     = pad_b_ff;
      overlong_in  = overlong_ff;
      op_in        = op_ff;
      num_in       = num_ff;
      res_in       = res_ff;
      ekind_in     = ekind_ff;
      etruth_in    = etruth_ff;
      eerr_in      = eerr_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      okind_in     = okind_ff;
      ochar_in     = ochar_ff;
      otruth_in    = otruth_ff;
      oerr_in      = oerr_ff;
      olast_in     = olast_ff;
      mdu_ctl      = '{start: 1'b0, divide: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            // Each digit beat enters the top of its operand's shift register.
            if (accept) begin
               if (!req_second_operand) begin
                  if (len_a_ff < MAX_LEN) begin
                     a_in     = {digit, a_ff[VAL_W-1:DIGIT_W]};
                     len_a_in = len_a_ff + 1'b1;
                  end else begin
                     overlong_in = 1'b1;
                  end
               end else begin
                  if (len_b_ff < MAX_LEN) begin
                     b_in     = {digit, b_ff[VAL_W-1:DIGIT_W]};
                     len_b_in = len_b_ff + 1'b1;
                  end else begin
                     overlong_in = 1'b1;
                  end
                  if (req_last_digit) begin
                     op_in    = op_type'(req_opcode);
                     pad_a_in = len_a_ff;
                     pad_b_in = len_b_in;
                     state_in = ST_ALIGN;
                  end
               end
            end
         end

         ST_ALIGN: begin
            if (!aligned) begin
               // Shift each operand down one digit until it sits at bit zero.
               if (pad_a_ff != MAX_LEN) begin
                  a_in     = {{DIGIT_W{1'b0}}, a_ff[VAL_W-1:DIGIT_W]};
                  pad_a_in = pad_a_ff + 1'b1;
               end
               if (pad_b_ff != MAX_LEN) begin
                  b_in     = {{DIGIT_W{1'b0}}, b_ff[VAL_W-1:DIGIT_W]};
                  pad_b_in = pad_b_ff + 1'b1;
               end
            end else begin
               // Operands are in place: pick the result or start the serial unit.
               num_in    = 1'b0;
               ekind_in  = KIND_ERROR;
               etruth_in = 1'b0;
               eerr_in   = ERR_NONE;
               state_in  = ST_EMIT;
               if (overlong_ff) begin
                  eerr_in = ERR_TOO_LONG;
               end else begin
                  unique case (op_ff)
                     OP_ADD: begin
                        if (sum[VAL_W]) begin
                           eerr_in = ERR_TOO_MANY;
                        end else begin
                           num_in = 1'b1;
                           res_in = sum[VAL_W-1:0];
                        end
                     end
                     OP_SUB: begin
                        if (diff[VAL_W]) begin
                           eerr_in = ERR_NEGATIVE;
                        end else begin
                           num_in = 1'b1;
                           res_in = diff[VAL_W-1:0];
                        end
                     end
                     OP_MUL: begin
                        mdu_ctl  = '{start: 1'b1, divide: 1'b0};
                        state_in = ST_ITER;
                     end
                     OP_DIV: begin
                        if (b_ff == '0) begin
                           eerr_in = ERR_DIV_ZERO;
                        end else begin
                           mdu_ctl  = '{start: 1'b1, divide: 1'b1};
                           state_in = ST_ITER;
                        end
                     end
                     OP_EQ: begin
                        ekind_in  = KIND_TRUTH;
                        etruth_in = eq;
                     end
                     OP_NE: begin
                        ekind_in  = KIND_TRUTH;
                        etruth_in = ~eq;
                     end
                     OP_LT: begin
                        ekind_in  = KIND_TRUTH;
                        etruth_in = lt;
                     end
                     OP_GT: begin
                        ekind_in  = KIND_TRUTH;
                        etruth_in = gt;
                     end
                     default: begin
                        ekind_in = KIND_ERROR;
                     end
                  endcase
               end
            end
         end

         ST_ITER: begin
            // Wait for the multiply or divide to finish.
            if (mdu_sts.done) begin
               state_in = ST_EMIT;
               if ((op_ff == OP_MUL) && mdu_sts.overflow) begin
                  num_in   = 1'b0;
                  ekind_in = KIND_ERROR;
                  eerr_in  = ERR_TOO_MANY;
               end else begin
                  num_in = 1'b1;
                  res_in = mdu_result;
               end
            end
         end

         ST_EMIT: begin
            // One result beat per free output slot, lowest digit first.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               ochar_in     = '0;
               otruth_in    = 1'b0;
               oerr_in      = ERR_NONE;
               olast_in     = 1'b1;
               if (!num_ff) begin
                  okind_in  = ekind_ff;
                  otruth_in = etruth_ff;
                  oerr_in   = eerr_ff;
               end else if (res_ff == '0) begin
                  okind_in = KIND_EMPTY;
               end else begin
                  okind_in = KIND_DIGIT;
                  ochar_in = ASCII_ZERO + 6'(res_ff[DIGIT_W-1:0]);
                  olast_in = (res_next == '0);
                  res_in   = res_next;
               end
               if (!num_ff || (res_ff == '0) || (res_next == '0)) begin
                  // Operation done: ready for the next pair of operands.
                  len_a_in    = '0;
                  len_b_in    = '0;
                  overlong_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         overlong_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         overlong_ff  <= overlong_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      pad_a_ff  <= pad_a_in;
      pad_b_ff  <= pad_b_in;
      op_ff     <= op_in;
      num_ff    <= num_in;
      res_ff    <= res_in;
      ekind_ff  <= ekind_in;
      etruth_ff <= etruth_in;
      eerr_ff   <= eerr_in;
      okind_ff  <= okind_in;
      ochar_ff  <= ochar_in;
      otruth_ff <= otruth_in;
      oerr_ff   <= oerr_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = okind_ff;
   assign rsp_result_char = ochar_ff;
   assign rsp_truth       = otruth_ff;
   assign rsp_error_code  = oerr_ff;
   assign rsp_last_result = olast_ff;

endmodule
